/* design/sbcrtc_pkg.sv */
`timescale 1ns / 1ps

package sbcrtc_pkg;

   // item commands
   localparam logic [1:0] CMD_REG_WRITE = 2'd0;
   localparam logic [1:0] CMD_REG_READ  = 2'd1;
   localparam logic [1:0] CMD_ADVANCE   = 2'd2;
   localparam logic [1:0] CMD_SET_TIME  = 2'd3;

   // register selects
   localparam logic [1:0] REG_PIN = 2'd0;
   localparam logic [1:0] REG_DIR = 2'd1;
   localparam logic [1:0] REG_EN  = 2'd2;

   typedef struct packed {
      logic        advance;
      logic        set;
      logic [23:0] tick;
      logic [5:0]  sec;
      logic [5:0]  min;
      logic [4:0]  hour;
      logic [2:0]  wday;
      logic [4:0]  mday;
      logic [3:0]  month;
      logic [7:0]  year;
   } clk_ctl_type;

   typedef struct packed {
      logic [7:0] year;
      logic [7:0] month;
      logic [7:0] day;
      logic [7:0] weekday;
      logic [7:0] hour;
      logic [7:0] minute;
      logic [7:0] second;
   } bcd_time_type;

   // BCD increment with digit carry; returns {wrapped, value}
   function automatic logic [8:0] bcd_bump(input logic [7:0] v, input logic [7:0] limit,
                                           input logic [7:0] reload);
      logic [7:0] x;
      x = {v[7:4], v[3:0] + 4'd1};
      if (x[3:0] >= 4'hA) begin
         x = {v[7:4] + 4'd1, 4'h0};
         if (x[7:4] >= 4'hA) x = 8'h00;
      end
      if (x >= limit) return {1'b1, reload};
      return {1'b0, x};
   endfunction

   // binary to two BCD digits, value taken modulo 100
   function automatic logic [7:0] to_bcd(input logic [7:0] v);
      logic [7:0] r;
      logic [3:0] tens;
      logic [7:0] ones;
      r = v;
      if (r >= 8'd200) r = r - 8'd200;
      else if (r >= 8'd100) r = r - 8'd100;
      tens = 4'd0;
      for (int k = 1; k <= 9; k++) begin
         if (r >= 8'(10 * k)) tens = 4'(k);
      end
      ones = r - 8'(tens) * 8'd10;
      return {tens, ones[3:0]};
   endfunction

endpackage

/* design/sbcrtc_clock.sv */
`timescale 1ns / 1ps

module sbcrtc_clock
   import sbcrtc_pkg::*;
#(
   parameter int TICKS_PER_SECOND = 16777216
) (
   input  logic         clock,
   input  logic         reset,
   input  clk_ctl_type  ctl,
   output bcd_time_type time_out
);

   localparam int DIV_W = $clog2(TICKS_PER_SECOND);
   localparam logic [DIV_W:0] TPS_W   = (DIV_W + 1)'(TICKS_PER_SECOND);
   localparam logic [23:0]    TPS_MAX = 24'(TICKS_PER_SECOND - 1);

   logic [DIV_W-1:0] div_ff, div_in;
   logic [7:0] sec_ff, sec_in, min_ff, min_in, hour_ff, hour_in;
   logic [7:0] wday_ff, wday_in, day_ff, day_in, mon_ff, mon_in, year_ff, year_in;

   logic [23:0]    amt;
   logic [DIV_W:0] sum;
   logic [DIV_W:0] sum_wrap;
   logic           roll;
   logic [7:0]     day_limit;
   logic [7:0]     set_s;
   logic [8:0]     b_sec, b_min, b_hour, b_wday, b_day, b_mon, b_year;

   always_comb begin
      amt      = (ctl.tick > TPS_MAX) ? TPS_MAX : ctl.tick;
      sum      = {1'b0, div_ff} + (DIV_W + 1)'(amt);
      sum_wrap = sum - TPS_W;
      roll     = (sum >= TPS_W);

      day_limit = 8'h32;
      if (mon_ff == 8'h02) begin
         // leap when the BCD year is a multiple of four
         day_limit = (year_ff[1:0] == (year_ff[4] ? 2'd2 : 2'd0)) ? 8'h30 : 8'h29;
      end else if (mon_ff == 8'h04 || mon_ff == 8'h06 || mon_ff == 8'h09 ||
                   mon_ff == 8'h11) begin
         day_limit = 8'h31;
      end

      b_sec  = bcd_bump(sec_ff, 8'h60, 8'h00);
      b_min  = bcd_bump(min_ff, 8'h60, 8'h00);
      b_hour = bcd_bump(hour_ff, 8'h24, 8'h00);
      b_wday = bcd_bump(wday_ff, 8'h07, 8'h00);
      b_day  = bcd_bump(day_ff, day_limit, 8'h01);
      b_mon  = bcd_bump(mon_ff, 8'h13, 8'h01);
      b_year = bcd_bump(year_ff, 8'hA0, 8'h00);

      set_s = to_bcd({2'b00, ctl.sec});

      div_in  = div_ff;
      sec_in  = sec_ff;
      min_in  = min_ff;
      hour_in = hour_ff;
      wday_in = wday_ff;
      day_in  = day_ff;
      mon_in  = mon_ff;
      year_in = year_ff;

      if (ctl.set) begin
         sec_in  = (set_s >= 8'h60) ? 8'h59 : set_s;
         min_in  = to_bcd({2'b00, ctl.min});
         hour_in = to_bcd({3'b000, ctl.hour});
         wday_in = to_bcd({5'b00000, ctl.wday});
         day_in  = to_bcd({3'b000, ctl.mday});
         mon_in  = to_bcd({4'b0000, ctl.month});
         year_in = to_bcd(ctl.year);
      end else if (ctl.advance) begin
         div_in = roll ? sum_wrap[DIV_W-1:0] : sum[DIV_W-1:0];
         if (roll) begin
            sec_in = b_sec[7:0];
            if (b_sec[8]) begin
               min_in = b_min[7:0];
               if (b_min[8]) begin
                  hour_in = b_hour[7:0];
                  if (b_hour[8]) begin
                     wday_in = b_wday[7:0];
                     day_in  = b_day[7:0];
                     if (b_day[8]) begin
                        mon_in = b_mon[7:0];
                        if (b_mon[8]) year_in = b_year[7:0];
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff  <= '0;
         sec_ff  <= 8'h00;
         min_ff  <= 8'h00;
         hour_ff <= 8'h00;
         wday_ff <= 8'h00;
         day_ff  <= 8'h01;
         mon_ff  <= 8'h01;
         year_ff <= 8'h00;
      end else begin
         div_ff  <= div_in;
         sec_ff  <= sec_in;
         min_ff  <= min_in;
         hour_ff <= hour_in;
         wday_ff <= wday_in;
         day_ff  <= day_in;
         mon_ff  <= mon_in;
         year_ff <= year_in;
      end
   end

   assign time_out = '{year: year_ff, month: mon_ff, day: day_ff, weekday: wday_ff,
                       hour: hour_ff, minute: min_ff, second: sec_ff};

   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, div_ff} < TPS_W) else $error("second divider out of range");

   a_sec_bound: assert property (@(posedge clock) disable iff (reset)
      sec_ff < 8'h60) else $error("second register out of range");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!ctl.advance && !ctl.set) |=> $stable(time_out))
      else $error("time changed without advance or set");

endmodule

/* design/serial_bcd_calendar_rtc_top.sv */
`timescale 1ns / 1ps

// Serial BCD calendar clock behind pin/data, direction and enable byte registers.
// Request channel (req_*): one item per transfer: a register write, a register
// read, a time advance by req_tick_cycles divider cycles, or a set-time load.
// Response channel (rsp_*): exactly one transfer per request; rsp_rdata holds the
// selected register on a read and zero for every other command.
// A request is taken into the request register, processed when the response
// register is empty or not stalled, and then offered from the response register.
// Throughput: one item per cycle while rsp_stall is low, set by the single
// processing stage between the request register and the response register.
// Reset clears the calendar to day 1, month 1, year 00, 00:00:00, weekday 0,
// zeroes the divider and the three registers and puts the serial protocol idle.
// While rsp_stall is high the response holds; one more request is taken into
// the request register and req_stall then rises until the response moves.
module serial_bcd_calendar_rtc_top
   import sbcrtc_pkg::*;
#(
   parameter int TICKS_PER_SECOND = 16777216,
   parameter int TRANSFER_BYTES   = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [1:0]  req_reg_sel,
   input  logic [15:0] req_wdata,
   input  logic [23:0] req_tick_cycles,
   input  logic [5:0]  req_set_sec,
   input  logic [5:0]  req_set_min,
   input  logic [4:0]  req_set_hour,
   input  logic [2:0]  req_set_wday,
   input  logic [4:0]  req_set_mday,
   input  logic [3:0]  req_set_month,
   input  logic [7:0]  req_set_year,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_rdata
);

   localparam int IDX_W = $clog2(TRANSFER_BYTES);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_CMD  = 2'd1;
   localparam logic [1:0] PH_SEND = 2'd2;
   localparam logic [1:0] PH_RECV = 2'd3;

   localparam logic [7:0] PCMD_RECV     = 8'h62;
   localparam logic [7:0] PCMD_STATUS   = 8'h63;
   localparam logic [7:0] PCMD_AGAIN    = 8'h64;
   localparam logic [7:0] PCMD_DATETIME = 8'h65;
   localparam logic [7:0] PCMD_TIME     = 8'h67;
   localparam logic [7:0] STATUS_BYTE   = 8'h40;

   // request register
   logic        in_valid_ff, in_valid_in;
   logic [1:0]  cmd_ff, sel_ff;
   logic [15:0] wdata_ff;
   logic [23:0] tick_ff;
   logic [5:0]  sec_ff, min_ff;
   logic [4:0]  hour_ff, mday_ff;
   logic [2:0]  wday_ff;
   logic [3:0]  month_ff;
   logic [7:0]  year_ff;

   // response register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rdata_ff, rdata_in;

   // register file and protocol state
   logic [7:0] pin_ff, pin_in, dir_ff, dir_in, en_ff, en_in;
   logic [7:0] cmdsh_ff, cmdsh_in;
   logic [2:0] tlen_ff, tlen_in;
   logic [5:0] bidx_ff, bidx_in;
   logic [1:0] phase_ff, phase_in;
   logic [7:0] tb_ff [TRANSFER_BYTES];
   logic [7:0] tb_in [TRANSFER_BYTES];

   logic             req_accept, advance;
   logic [7:0]       cmdsh_new;
   logic [5:0]       bidx_inc;
   logic [2:0]       idx;
   logic [IDX_W-1:0] idx_addr;
   logic             idx_ok;
   logic [7:0]       send_byte;
   logic             end_hit;

   clk_ctl_type  clk_ctl;
   bcd_time_type now;

   assign advance    = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   assign in_valid_in  = req_accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   assign clk_ctl = '{advance: advance && (cmd_ff == CMD_ADVANCE),
                      set: advance && (cmd_ff == CMD_SET_TIME),
                      tick: tick_ff, sec: sec_ff, min: min_ff, hour: hour_ff,
                      wday: wday_ff, mday: mday_ff, month: month_ff, year: year_ff};

   sbcrtc_clock #(
      .TICKS_PER_SECOND(TICKS_PER_SECOND)
   ) u_clock (
      .clock   (clock),
      .reset   (reset),
      .ctl     (clk_ctl),
      .time_out(now)
   );

   always_comb begin
      cmdsh_new = cmdsh_ff | (8'({7'd0, wdata_ff[1]}) << (3'd7 - bidx_ff[2:0]));
      bidx_inc  = bidx_ff + 6'd1;
      idx       = bidx_ff[5:3];
      idx_addr  = IDX_W'(idx);
      idx_ok    = (32'(idx) < TRANSFER_BYTES);
      send_byte = idx_ok ? tb_ff[idx_addr] : 8'h00;
      end_hit   = (bidx_inc == {tlen_ff, 3'b000});

      pin_in   = pin_ff;
      dir_in   = dir_ff;
      en_in    = en_ff;
      cmdsh_in = cmdsh_ff;
      tlen_in  = tlen_ff;
      bidx_in  = bidx_ff;
      phase_in = phase_ff;
      tb_in    = tb_ff;
      rdata_in = 8'h00;

      if (advance) begin
         unique case (cmd_ff)
            CMD_REG_WRITE: begin
               case (sel_ff)
                  REG_EN:  en_in  = wdata_ff[7:0];
                  REG_DIR: dir_in = wdata_ff[7:0];
                  REG_PIN: begin
                     if (!en_ff[0]) begin
                        // disabled: pin write ignored
                     end else if (phase_ff == PH_IDLE && pin_ff == 8'h01 &&
                                  wdata_ff == 16'd5) begin
                        // start sequence, pin register keeps its value
                        phase_in = PH_CMD;
                        bidx_in  = 6'd0;
                        cmdsh_in = 8'h00;
                     end else if (pin_ff[0] || !wdata_ff[0]) begin
                        pin_in = wdata_ff[7:0];
                     end else begin
                        // rising clock line: at most one bit moves
                        pin_in = wdata_ff[7:0];
                        unique case (phase_ff)
                           PH_CMD: begin
                              cmdsh_in = cmdsh_new;
                              if (bidx_inc >= 6'd8) begin
                                 bidx_in = 6'd0;
                                 unique case (cmdsh_new)
                                    PCMD_RECV: begin
                                       phase_in = PH_RECV;
                                       tlen_in  = 3'd1;
                                    end
                                    PCMD_STATUS: begin
                                       tlen_in  = 3'd1;
                                       tb_in[0] = STATUS_BYTE;
                                       phase_in = PH_SEND;
                                    end
                                    PCMD_AGAIN: begin
                                    end
                                    PCMD_DATETIME: begin
                                       tlen_in  = 3'd7;
                                       tb_in[0] = now.year;
                                       tb_in[1] = now.month;
                                       tb_in[2] = now.day;
                                       tb_in[3] = now.weekday;
                                       tb_in[4] = now.hour;
                                       tb_in[5] = now.minute;
                                       tb_in[6] = now.second;
                                       phase_in = PH_SEND;
                                    end
                                    PCMD_TIME: begin
                                       tlen_in  = 3'd3;
                                       tb_in[0] = now.hour;
                                       tb_in[1] = now.minute;
                                       tb_in[2] = now.second;
                                       phase_in = PH_SEND;
                                    end
                                    default: phase_in = PH_IDLE;
                                 endcase
                              end else begin
                                 bidx_in = bidx_inc;
                              end
                           end
                           PH_SEND: begin
                              if (!dir_ff[1]) begin
                                 pin_in[1] = send_byte[bidx_ff[2:0]];
                                 bidx_in   = end_hit ? 6'd0 : bidx_inc;
                                 if (end_hit) phase_in = PH_IDLE;
                              end
                           end
                           PH_RECV: begin
                              if (dir_ff[1]) begin
                                 if (idx_ok) tb_in[idx_addr] = {wdata_ff[1], tb_ff[idx_addr][7:1]};
                                 bidx_in = end_hit ? 6'd0 : bidx_inc;
                                 if (end_hit) phase_in = PH_IDLE;
                              end
                           end
                           PH_IDLE: begin
                           end
                        endcase
                     end
                  end
                  default: begin
                  end
               endcase
            end
            CMD_REG_READ: begin
               case (sel_ff)
                  REG_EN:  rdata_in = en_ff;
                  REG_DIR: rdata_in = dir_ff;
                  REG_PIN: rdata_in = pin_ff;
                  default: rdata_in = 8'h00;
               endcase
            end
            CMD_ADVANCE: begin
            end
            CMD_SET_TIME: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pin_ff       <= 8'h00;
         dir_ff       <= 8'h00;
         en_ff        <= 8'h00;
         cmdsh_ff     <= 8'h00;
         tlen_ff      <= 3'd0;
         bidx_ff      <= 6'd0;
         phase_ff     <= PH_IDLE;
         for (int i = 0; i < TRANSFER_BYTES; i++) tb_ff[i] <= 8'h00;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         pin_ff       <= pin_in;
         dir_ff       <= dir_in;
         en_ff        <= en_in;
         cmdsh_ff     <= cmdsh_in;
         tlen_ff      <= tlen_in;
         bidx_ff      <= bidx_in;
         phase_ff     <= phase_in;
         tb_ff        <= tb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff   <= req_cmd;
         sel_ff   <= req_reg_sel;
         wdata_ff <= req_wdata;
         tick_ff  <= req_tick_cycles;
         sec_ff   <= req_set_sec;
         min_ff   <= req_set_min;
         hour_ff  <= req_set_hour;
         wday_ff  <= req_set_wday;
         mday_ff  <= req_set_mday;
         month_ff <= req_set_month;
         year_ff  <= req_set_year;
      end
      if (advance) rdata_ff <= rdata_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_rdata = rdata_ff;

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff))
      else $error("response without a queued request");

   a_idle_index: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (bidx_ff == 6'd0))
      else $error("bit index not cleared while idle");

   a_cmd_index: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_CMD) |-> (bidx_ff < 6'd8))
      else $error("command bit index overrun");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && rsp_valid_ff && rsp_stall) |=>
         ($stable(pin_ff) && $stable(phase_ff) && $stable(bidx_ff)))
      else $error("state changed while response stalled");

endmodule

/* tb/sv/serial_bcd_calendar_rtc_top_test.sv */
`timescale 1ns / 1ps

module serial_bcd_calendar_rtc_top_test;
   import sbcrtc_pkg::*;

   localparam int TICKS_PER_SECOND = 16777216;
   localparam logic [1:0] REG_NONE = 2'd3;

   // serial link commands and the status reply
   localparam logic [7:0] LINK_ABORT    = 8'h60;
   localparam logic [7:0] LINK_RECV     = 8'h62;
   localparam logic [7:0] LINK_STATUS   = 8'h63;
   localparam logic [7:0] LINK_CHAIN    = 8'h64;
   localparam logic [7:0] LINK_DATETIME = 8'h65;
   localparam logic [7:0] LINK_TIME     = 8'h67;
   localparam logic [7:0] STATUS_BYTE   = 8'h40;

   typedef enum logic [1:0] {PH_IDLE, PH_CMD, PH_SEND, PH_RECV} link_phase_type;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [1:0]  sel;
      logic [15:0] wdata;
      logic [23:0] tick;
      logic [5:0]  sec;
      logic [5:0]  min;
      logic [4:0]  hour;
      logic [2:0]  wday;
      logic [4:0]  mday;
      logic [3:0]  month;
      logic [7:0]  year;
   } rtc_item_type;

   typedef struct {
      rtc_item_type it;
      bit           has_lit;
      logic [7:0]   lit;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_cmd = '0;
   logic [1:0]  req_reg_sel = '0;
   logic [15:0] req_wdata = '0;
   logic [23:0] req_tick_cycles = '0;
   logic [5:0]  req_set_sec = '0;
   logic [5:0]  req_set_min = '0;
   logic [4:0]  req_set_hour = '0;
   logic [2:0]  req_set_wday = '0;
   logic [4:0]  req_set_mday = '0;
   logic [3:0]  req_set_month = '0;
   logic [7:0]  req_set_year = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_rdata;

   serial_bcd_calendar_rtc_top #(
      .TICKS_PER_SECOND(TICKS_PER_SECOND),
      .TRANSFER_BYTES(8)
   ) DUT (.*);

   always #1 clock = ~clock;

   // clock model state, reset values
   logic [7:0]  cal_sec = 8'h00, cal_min = 8'h00, cal_hour = 8'h00, cal_wday = 8'h00;
   logic [7:0]  cal_day = 8'h01, cal_mon = 8'h01, cal_year = 8'h00;
   int unsigned div_acc = 0;
   logic [7:0]  pin_q = 8'h00, dir_q = 8'h00, en_q = 8'h00;
   logic [7:0]  cmd_shift_q = 8'h00;
   logic [2:0]  xfer_len = 3'd0;
   logic [5:0]  bit_pos = 6'd0;
   link_phase_type link_phase = PH_IDLE;
   logic [7:0]  xfer_bytes [0:7] = '{default: 8'h00};

   logic [7:0]  exp_rdata_q [$];
   logic [7:0]  rsp_want;
   directed_row_type directed_rows [$];
   int          errors = 0;
   int          requests_taken = 0;
   int          responses_seen = 0;
   int          seconds_rolled = 0;
   int          link_cmds_run = 0;
   int          stall_left = 0;
   bit          quiet = 1'b0;
   bit          long_hold_req = 1'b0;

   task automatic report_mismatch(input string what, input logic [7:0] want,
                                  input logic [7:0] got);
      $display("ERROR: response %0d: %s: expected %02h got %02h", responses_seen, what,
               want, got);
      errors++;
   endtask

   // ---------------------------------------------------------------- model

   // returns {wrapped, value}
   function automatic logic [8:0] bcd_inc(input logic [7:0] v, input logic [7:0] limit,
                                          input logic [7:0] reload);
      logic [7:0] x;
      x = {v[7:4], v[3:0] + 4'd1};
      if (x[3:0] >= 4'hA) begin
         x = {v[7:4], 4'h0} + 8'h10;
         if (x[7:4] >= 4'hA) x = {4'h0, x[3:0]};
      end
      if (x >= limit) return {1'b1, reload};
      return {1'b0, x};
   endfunction

   function automatic logic [7:0] bin2bcd(input int unsigned v);
      int unsigned m;
      m = v % 100;
      return 8'((m / 10) * 16 + m % 10);
   endfunction

   task automatic roll_second();
      logic [8:0] r;
      logic [7:0] day_lim;
      seconds_rolled++;
      r = bcd_inc(cal_sec, 8'h60, 8'h00);
      cal_sec = r[7:0];
      if (!r[8]) return;
      r = bcd_inc(cal_min, 8'h60, 8'h00);
      cal_min = r[7:0];
      if (!r[8]) return;
      r = bcd_inc(cal_hour, 8'h24, 8'h00);
      cal_hour = r[7:0];
      if (!r[8]) return;
      day_lim = 8'h32;
      if (cal_mon == 8'h02) begin
         // leap when the BCD year is a multiple of four
         day_lim = (cal_year[1:0] == (cal_year[4] ? 2'd2 : 2'd0)) ? 8'h30 : 8'h29;
      end else if (cal_mon == 8'h04 || cal_mon == 8'h06 || cal_mon == 8'h09 ||
                   cal_mon == 8'h11) begin
         day_lim = 8'h31;
      end
      r = bcd_inc(cal_wday, 8'h07, 8'h00);
      cal_wday = r[7:0];
      r = bcd_inc(cal_day, day_lim, 8'h01);
      cal_day = r[7:0];
      if (!r[8]) return;
      r = bcd_inc(cal_mon, 8'h13, 8'h01);
      cal_mon = r[7:0];
      if (!r[8]) return;
      r = bcd_inc(cal_year, 8'hA0, 8'h00);
      cal_year = r[7:0];
   endtask

   task automatic run_link_cmd();
      link_cmds_run++;
      case (cmd_shift_q)
         LINK_RECV: begin
            link_phase = PH_RECV;
            xfer_len = 3'd1;
         end
         LINK_STATUS: begin
            xfer_len = 3'd1;
            xfer_bytes[0] = STATUS_BYTE;
            link_phase = PH_SEND;
         end
         LINK_CHAIN: ;
         LINK_DATETIME: begin
            xfer_len = 3'd7;
            xfer_bytes[0] = cal_year;
            xfer_bytes[1] = cal_mon;
            xfer_bytes[2] = cal_day;
            xfer_bytes[3] = cal_wday;
            xfer_bytes[4] = cal_hour;
            xfer_bytes[5] = cal_min;
            xfer_bytes[6] = cal_sec;
            link_phase = PH_SEND;
         end
         LINK_TIME: begin
            xfer_len = 3'd3;
            xfer_bytes[0] = cal_hour;
            xfer_bytes[1] = cal_min;
            xfer_bytes[2] = cal_sec;
            link_phase = PH_SEND;
         end
         default: link_phase = PH_IDLE;
      endcase
   endtask

   task automatic pin_write(input logic [15:0] value);
      logic [2:0] idx;
      if (!en_q[0]) return;
      // start sequence compares the full 16 bits and leaves the pin alone
      if (link_phase == PH_IDLE && pin_q == 8'h01 && value == 16'd5) begin
         link_phase = PH_CMD;
         bit_pos = 6'd0;
         cmd_shift_q = 8'h00;
         return;
      end
      if (pin_q[0] || !value[0]) begin
         pin_q = value[7:0];
         return;
      end
      pin_q = value[7:0];
      idx = bit_pos[5:3];
      case (link_phase)
         PH_CMD: begin
            cmd_shift_q = cmd_shift_q | (8'(value[1]) << (3'd7 - bit_pos[2:0]));
            bit_pos = bit_pos + 6'd1;
            if (bit_pos >= 6'd8) begin
               bit_pos = 6'd0;
               run_link_cmd();
            end
         end
         PH_SEND: begin
            if (!dir_q[1]) begin
               pin_q[1] = xfer_bytes[idx][bit_pos[2:0]];
               bit_pos = bit_pos + 6'd1;
               if (bit_pos == {xfer_len, 3'b000}) begin
                  bit_pos = 6'd0;
                  link_phase = PH_IDLE;
               end
            end
         end
         PH_RECV: begin
            if (dir_q[1]) begin
               xfer_bytes[idx] = {value[1], xfer_bytes[idx][7:1]};
               bit_pos = bit_pos + 6'd1;
               if (bit_pos == {xfer_len, 3'b000}) begin
                  bit_pos = 6'd0;
                  link_phase = PH_IDLE;
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic predict_item(input rtc_item_type it, output logic [7:0] rd);
      int unsigned acc;
      rd = 8'h00;
      case (it.cmd)
         CMD_REG_WRITE: begin
            if (it.sel == REG_EN) en_q = it.wdata[7:0];
            else if (it.sel == REG_DIR) dir_q = it.wdata[7:0];
            else if (it.sel == REG_PIN) pin_write(it.wdata);
         end
         CMD_REG_READ: begin
            if (it.sel == REG_EN) rd = en_q;
            else if (it.sel == REG_DIR) rd = dir_q;
            else if (it.sel == REG_PIN) rd = pin_q;
         end
         CMD_ADVANCE: begin
            acc = it.tick;
            if (acc > TICKS_PER_SECOND - 1) acc = TICKS_PER_SECOND - 1;
            acc = acc + div_acc;
            if (acc >= TICKS_PER_SECOND) begin
               acc = acc - TICKS_PER_SECOND;
               roll_second();
            end
            div_acc = acc;
         end
         default: begin
            cal_sec = bin2bcd(it.sec);
            cal_min = bin2bcd(it.min);
            cal_hour = bin2bcd(it.hour);
            cal_wday = bin2bcd(it.wday);
            cal_day = bin2bcd(it.mday);
            cal_mon = bin2bcd(it.month);
            cal_year = bin2bcd(it.year);
            if (cal_sec >= 8'h60) cal_sec = 8'h59;
         end
      endcase
   endtask

   // ---------------------------------------------------------------- items

   function automatic rtc_item_type rand_item();
      rtc_item_type it;
      it.cmd = 2'($urandom);
      it.sel = 2'($urandom);
      it.wdata = 16'($urandom);
      it.tick = 24'($urandom);
      it.sec = 6'($urandom);
      it.min = 6'($urandom);
      it.hour = 5'($urandom);
      it.wday = 3'($urandom);
      it.mday = 5'($urandom);
      it.month = 4'($urandom);
      it.year = 8'($urandom);
      return it;
   endfunction

   function automatic rtc_item_type reg_wr(input logic [1:0] sel, input logic [15:0] data);
      rtc_item_type it;
      it = rand_item();
      it.cmd = CMD_REG_WRITE;
      it.sel = sel;
      it.wdata = data;
      return it;
   endfunction

   function automatic rtc_item_type reg_rd(input logic [1:0] sel);
      rtc_item_type it;
      it = rand_item();
      it.cmd = CMD_REG_READ;
      it.sel = sel;
      return it;
   endfunction

   function automatic rtc_item_type advance_by(input logic [23:0] tick);
      rtc_item_type it;
      it = rand_item();
      it.cmd = CMD_ADVANCE;
      it.tick = tick;
      return it;
   endfunction

   function automatic rtc_item_type set_clock(input logic [5:0] sec, input logic [5:0] min,
                                              input logic [4:0] hour, input logic [2:0] wday,
                                              input logic [4:0] mday, input logic [3:0] month,
                                              input logic [7:0] year);
      rtc_item_type it;
      it = rand_item();
      it.cmd = CMD_SET_TIME;
      it.sec = sec;
      it.min = min;
      it.hour = hour;
      it.wday = wday;
      it.mday = mday;
      it.month = month;
      it.year = year;
      return it;
   endfunction

   function automatic logic [7:0] pick_link_cmd();
      case ($urandom_range(0, 9))
         0: return LINK_ABORT;
         1: return LINK_RECV;
         2: return LINK_STATUS;
         3: return LINK_CHAIN;
         4, 5, 6: return LINK_DATETIME;
         7, 8: return LINK_TIME;
         default: return 8'($urandom);
      endcase
   endfunction

   // ---------------------------------------------------------------- driving

   task automatic send_item(input rtc_item_type it, input bit has_lit, input logic [7:0] lit);
      int gap;
      logic [7:0] want;
      gap = (!quiet && $urandom_range(0, 99) < 12) ? $urandom_range(1, 8) : 0;
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= it.cmd;
      req_reg_sel <= it.sel;
      req_wdata <= it.wdata;
      req_tick_cycles <= it.tick;
      req_set_sec <= it.sec;
      req_set_min <= it.min;
      req_set_hour <= it.hour;
      req_set_wday <= it.wday;
      req_set_mday <= it.mday;
      req_set_month <= it.month;
      req_set_year <= it.year;
      do @(posedge clock); while (req_stall);
      predict_item(it, want);
      if (has_lit) want = lit;
      exp_rdata_q.push_back(want);
      requests_taken++;
   endtask

   task automatic send(input rtc_item_type it);
      send_item(it, 1'b0, 8'h00);
   endtask

   // falling then rising edge on pin bit 0, data on bit 1, junk above
   task automatic clock_bit(input logic b);
      send(reg_wr(REG_PIN, {14'($urandom), b, 1'b0}));
      send(reg_wr(REG_PIN, {14'($urandom), b, 1'b1}));
   endtask

   task automatic serial_exchange(input logic [7:0] code);
      int nbits;
      int guard;
      bit sending;
      bit dir_in;
      logic [7:0] follow;
      // finish whatever transfer an earlier broken sequence left open
      guard = 0;
      while (link_phase != PH_IDLE && guard < 100) begin
         if (!en_q[0]) send(reg_wr(REG_EN, {15'($urandom), 1'b1}));
         if (link_phase == PH_SEND && dir_q[1])
            send(reg_wr(REG_DIR, 16'($urandom) & ~16'h0002));
         if (link_phase == PH_RECV && !dir_q[1])
            send(reg_wr(REG_DIR, 16'($urandom) | 16'h0002));
         clock_bit(link_phase == PH_CMD ? 1'b1 : 1'($urandom));
         guard++;
      end
      if (!en_q[0] || $urandom_range(0, 7) == 0)
         send(reg_wr(REG_EN, {15'($urandom), 1'($urandom_range(0, 19) != 0)}));
      dir_in = (code == LINK_RECV) ^ ($urandom_range(0, 7) == 0);
      send(reg_wr(REG_DIR, {14'($urandom), dir_in, 1'($urandom)}));
      send(reg_wr(REG_PIN, 16'h0001));
      send(reg_wr(REG_PIN, 16'h0005));
      for (int i = 7; i >= 0; i--) clock_bit(code[i]);
      if (link_phase == PH_CMD && code == LINK_CHAIN) begin
         follow = pick_link_cmd();
         for (int i = 7; i >= 0; i--) clock_bit(follow[i]);
      end
      if (link_phase == PH_SEND || link_phase == PH_RECV) begin
         sending = (link_phase == PH_SEND);
         nbits = 8 * xfer_len;
         if ($urandom_range(0, 9) == 0) nbits = $urandom_range(0, nbits);
         for (int i = 0; i < nbits; i++) begin
            clock_bit(1'($urandom));
            if (sending || $urandom_range(0, 3) == 0) send(reg_rd(REG_PIN));
         end
      end
      if ($urandom_range(0, 3) == 0) send(reg_rd(2'($urandom)));
   endtask

   task automatic time_sequence();
      logic [23:0] tick;
      send(set_clock(
         $urandom_range(0, 3) == 0 ? 6'($urandom) : 6'($urandom_range(57, 60)),
         $urandom_range(0, 3) == 0 ? 6'($urandom) : 6'd59,
         $urandom_range(0, 3) == 0 ? 5'($urandom) : 5'd23,
         3'($urandom),
         $urandom_range(0, 3) == 0 ? 5'($urandom) : 5'($urandom_range(28, 31)),
         $urandom_range(0, 3) == 0 ? 4'($urandom) : 4'($urandom_range(0, 2) == 0 ? 2 :
                                                    $urandom_range(0, 1) ? 12 : 4),
         8'($urandom)));
      repeat ($urandom_range(1, 6)) begin
         case ($urandom_range(0, 4))
            0: tick = 24'd0;
            1: tick = 24'hFFFFFF;
            2: tick = 24'h800000 + 24'($urandom_range(0, 16));
            default: tick = 24'($urandom);
         endcase
         send(advance_by(tick));
      end
      serial_exchange($urandom_range(0, 1) ? LINK_DATETIME : LINK_TIME);
   endtask

   // ---------------------------------------------------------------- response side

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         responses_seen++;
         if (exp_rdata_q.size() == 0) begin
            report_mismatch("response with no request outstanding", 8'h00, rsp_rdata);
         end else begin
            rsp_want = exp_rdata_q.pop_front();
            if (rsp_rdata !== rsp_want) report_mismatch("rsp_rdata", rsp_want, rsp_rdata);
         end
      end
      if (long_hold_req) begin
         long_hold_req = 1'b0;
         stall_left = 64;
      end else if (stall_left == 0 && !quiet && $urandom_range(0, 99) < 10) begin
         stall_left = $urandom_range(1, 8);
      end
      rsp_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
   end

   // ---------------------------------------------------------------- main

   initial begin
      bit hold_done;
      bit drain_done;
      int pick;
      hold_done = 1'b0;
      drain_done = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      directed_rows.push_back('{reg_rd(REG_PIN), 1'b1, 8'h00});
      directed_rows.push_back('{reg_rd(REG_DIR), 1'b1, 8'h00});
      directed_rows.push_back('{reg_rd(REG_EN), 1'b1, 8'h00});
      directed_rows.push_back('{reg_rd(REG_NONE), 1'b1, 8'h00});
      directed_rows.push_back('{reg_wr(REG_NONE, 16'hFFFF), 1'b1, 8'h00});
      // pin write while disabled is dropped
      directed_rows.push_back('{reg_wr(REG_PIN, 16'hFFFF), 1'b1, 8'h00});
      directed_rows.push_back('{reg_rd(REG_PIN), 1'b1, 8'h00});
      directed_rows.push_back('{reg_wr(REG_DIR, 16'hFFFF), 1'b1, 8'h00});
      directed_rows.push_back('{reg_rd(REG_DIR), 1'b1, 8'hFF});
      directed_rows.push_back('{reg_wr(REG_EN, 16'h0000), 1'b1, 8'h00});
      directed_rows.push_back('{reg_rd(REG_EN), 1'b1, 8'h00});
      directed_rows.push_back('{reg_wr(REG_EN, 16'hFF01), 1'b1, 8'h00});
      directed_rows.push_back('{reg_rd(REG_EN), 1'b1, 8'h01});
      directed_rows.push_back('{reg_wr(REG_PIN, 16'h0001), 1'b0, 8'h00});
      // 0x0105 is not a start: the compare is on all 16 bits
      directed_rows.push_back('{reg_wr(REG_PIN, 16'h0105), 1'b0, 8'h00});
      directed_rows.push_back('{reg_rd(REG_PIN), 1'b1, 8'h05});
      directed_rows.push_back('{reg_wr(REG_PIN, 16'h0001), 1'b0, 8'h00});
      directed_rows.push_back('{reg_wr(REG_PIN, 16'h0005), 1'b0, 8'h00});
      directed_rows.push_back('{reg_rd(REG_PIN), 1'b1, 8'h01});
      directed_rows.push_back('{set_clock(6'd60, 6'd59, 5'd23, 3'd6, 5'd31, 4'd12, 8'd199),
                                1'b0, 8'h00});
      directed_rows.push_back('{advance_by(24'hFFFFFF), 1'b0, 8'h00});
      directed_rows.push_back('{advance_by(24'h000001), 1'b0, 8'h00});
      directed_rows.push_back('{set_clock(6'd63, 6'd63, 5'd31, 3'd7, 5'd31, 4'd15, 8'd255),
                                1'b0, 8'h00});
      directed_rows.push_back('{advance_by(24'h000000), 1'b0, 8'h00});
      directed_rows.push_back('{reg_wr(REG_DIR, 16'h0000), 1'b0, 8'h00});

      foreach (directed_rows[i])
         send_item(directed_rows[i].it, directed_rows[i].has_lit, directed_rows[i].lit);

      while (requests_taken < 1850) begin
         // response side holds off while requests keep coming
         if (!hold_done && requests_taken >= 500) begin
            hold_done = 1'b1;
            long_hold_req = 1'b1;
         end
         // request side goes quiet until everything has come back
         if (!drain_done && requests_taken >= 1100) begin
            drain_done = 1'b1;
            req_valid <= 1'b0;
            do @(posedge clock); while (exp_rdata_q.size() != 0);
         end
         quiet = (requests_taken >= 1650);
         pick = $urandom_range(0, 99);
         if (pick < 55) serial_exchange(pick_link_cmd());
         else if (pick < 80) time_sequence();
         else repeat ($urandom_range(1, 4)) send(rand_item());
      end

      req_valid <= 1'b0;
      do @(posedge clock); while (exp_rdata_q.size() != 0);
      repeat (8) @(posedge clock);
      if (exp_rdata_q.size() != 0)
         report_mismatch("request left without a response", exp_rdata_q[0], 8'h00);

      $display("Covered %0d requests / %0d responses: register access, serial link", 
               requests_taken, responses_seen);
      $display("commands decoded %0d, calendar seconds rolled %0d.", link_cmds_run,
               seconds_rolled);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Timeout: requests or responses stopped moving");
      $display("FAIL");
      $finish;
   end

endmodule

/* serial_bcd_calendar_rtc_top.f */
design/sbcrtc_pkg.sv
design/sbcrtc_clock.sv
design/serial_bcd_calendar_rtc_top.sv
tb/sv/serial_bcd_calendar_rtc_top_test.sv
